>>> sv/mev_pkg.sv
package mev_pkg;

	typedef enum logic [1:0] {
		MODE_UTF8   = 2'd0,
		MODE_GB2312 = 2'd1,
		MODE_GBK    = 2'd2,
		MODE_BIG5   = 2'd3
	} mode_t;

	// Scan state carried from one byte to the next.
	typedef struct packed {
		logic [1:0] trail_pending;
		logic       error_seen;
	} scan_state_t;

	localparam logic [7:0] ASCII_MAX       = 8'h7F;
	localparam logic [7:0] UTF8_TRAIL_LO   = 8'h80;
	localparam logic [7:0] UTF8_TRAIL_HI   = 8'hBF;
	localparam logic [7:0] UTF8_LEAD2_LO   = 8'hC0;
	localparam logic [7:0] UTF8_LEAD2_HI   = 8'hDF;
	localparam logic [7:0] UTF8_LEAD3_LO   = 8'hE0;
	localparam logic [7:0] UTF8_LEAD3_HI   = 8'hEF;
	localparam logic [7:0] UTF8_LEAD4_LO   = 8'hF0;
	localparam logic [7:0] UTF8_LEAD4_HI   = 8'hF7;
	localparam logic [7:0] GB2312_LEAD_LO  = 8'hA1;
	localparam logic [7:0] GB2312_LEAD_HI  = 8'hF7;
	localparam logic [7:0] GB2312_TRAIL_LO = 8'hA1;
	localparam logic [7:0] GB2312_TRAIL_HI = 8'hFE;
	localparam logic [7:0] GBK_LEAD_LO     = 8'h81;
	localparam logic [7:0] GBK_LEAD_HI     = 8'hFE;
	localparam logic [7:0] GBK_TRAIL_LO    = 8'h40;
	localparam logic [7:0] GBK_TRAIL_HI    = 8'hFE;
	localparam logic [7:0] BIG5_LEAD_LO    = 8'hA1;
	localparam logic [7:0] BIG5_LEAD_HI    = 8'hF9;
	localparam logic [7:0] BIG5_TRAIL1_LO  = 8'h40;
	localparam logic [7:0] BIG5_TRAIL1_HI  = 8'h7E;
	localparam logic [7:0] BIG5_TRAIL2_LO  = 8'hA1;
	localparam logic [7:0] BIG5_TRAIL2_HI  = 8'hFE;

	function automatic logic in_range(input logic [7:0] b, input logic [7:0] lo,
			input logic [7:0] hi);
		return (b >= lo) && (b <= hi);
	endfunction

endpackage

>>> sv/multibyte_encoding_validator_top.sv
// A byte taken in is held in the input stage and checked combinationally; when
// it advances, its verdict (for a final byte) is loaded into the result register.
// One byte per cycle is taken in, except that a final byte waits in the input
// stage while the result register is full and not being drained.
// Reset (arst_n low, asynchronous) clears the mode to UTF-8, the scan state and
// both valid flags; payload registers are not reset.
module multibyte_encoding_validator_top import mev_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	// Mode register write port.
	input  logic       mode_we,
	input  logic [1:0] encoding_mode,
	// Byte channel.
	input  logic       data_valid,
	output logic       data_ready,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	// Result channel.
	output logic       result_valid,
	input  logic       result_ready,
	output logic       stream_ok
);

	// The mode register. The user must write it only while the block is idle; the block itself does not enforce this.
	mode_t mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_UTF8;
		end else if (mode_we) begin
			mode_q <= mode_t'(encoding_mode);
		end
	end

	// Input stage: one byte held for the check logic.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       final_s1;

	// Result register.
	logic       result_valid_q;
	logic       stream_ok_q;

	// Scan state carried between bytes of one stream.
	scan_state_t state_q;
	scan_state_t state_nxt;
	logic        ok_nxt;

	logic out_free;
	logic advance;

	// The result register can take a new verdict when it is empty or being drained.
	assign out_free = !result_valid_q || result_ready;
	// A non-final byte leaves the input stage freely; a final byte needs room
	// in the result register for its verdict.
	assign advance    = valid_s1 && (!final_s1 || out_free);
	assign data_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data_ready) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data_ready && data_valid) begin
			byte_s1  <= data_byte;
			final_s1 <= final_byte;
		end
	end

	mev_byte_check u_check (
		.mode      (mode_q),
		.data_byte (byte_s1),
		.cur       (state_q),
		.nxt       (state_nxt),
		.stream_ok (ok_nxt)
	);

	// The scan state follows each byte; the final byte of a stream returns it
	// to the start so the next byte opens a new stream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			if (final_s1) begin
				state_q <= '0;
			end else begin
				state_q <= state_nxt;
			end
		end
	end

	// Only a final byte produces a result transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= advance && final_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && final_s1) begin
			stream_ok_q <= ok_nxt;
		end
	end

	assign result_valid = result_valid_q;
	assign stream_ok    = stream_ok_q;

endmodule

>>> sv/mev_byte_check.sv
module mev_byte_check import mev_pkg::*; (
	input  mode_t       mode,
	input  logic [7:0]  data_byte,
	input  scan_state_t cur,
	output scan_state_t nxt,
	output logic        stream_ok
);

	logic       trail_ok;
	logic       lead_ok;
	logic [1:0] lead_trails;

	always_comb begin
		unique case (mode)
			MODE_UTF8:   trail_ok = in_range(data_byte, UTF8_TRAIL_LO, UTF8_TRAIL_HI);
			MODE_GB2312: trail_ok = in_range(data_byte, GB2312_TRAIL_LO, GB2312_TRAIL_HI);
			MODE_GBK:    trail_ok = in_range(data_byte, GBK_TRAIL_LO, GBK_TRAIL_HI);
			MODE_BIG5:   trail_ok = in_range(data_byte, BIG5_TRAIL1_LO, BIG5_TRAIL1_HI) ||
				in_range(data_byte, BIG5_TRAIL2_LO, BIG5_TRAIL2_HI);
			default:     trail_ok = 1'b0;
		endcase
	end

	always_comb begin
		lead_ok     = 1'b0;
		lead_trails = 2'd0;
		if (data_byte <= ASCII_MAX) begin
			lead_ok = 1'b1;
		end else begin
			unique case (mode)
				MODE_UTF8: begin
					if (in_range(data_byte, UTF8_LEAD2_LO, UTF8_LEAD2_HI)) begin
						lead_ok     = 1'b1;
						lead_trails = 2'd1;
					end else if (in_range(data_byte, UTF8_LEAD3_LO, UTF8_LEAD3_HI)) begin
						lead_ok     = 1'b1;
						lead_trails = 2'd2;
					end else if (in_range(data_byte, UTF8_LEAD4_LO, UTF8_LEAD4_HI)) begin
						lead_ok     = 1'b1;
						lead_trails = 2'd3;
					end
				end
				MODE_GB2312: begin
					lead_ok     = in_range(data_byte, GB2312_LEAD_LO, GB2312_LEAD_HI);
					lead_trails = 2'd1;
				end
				MODE_GBK: begin
					lead_ok     = in_range(data_byte, GBK_LEAD_LO, GBK_LEAD_HI);
					lead_trails = 2'd1;
				end
				MODE_BIG5: begin
					lead_ok     = in_range(data_byte, BIG5_LEAD_LO, BIG5_LEAD_HI);
					lead_trails = 2'd1;
				end
				default: begin
					lead_ok     = 1'b0;
					lead_trails = 2'd0;
				end
			endcase
		end
	end

	always_comb begin
		nxt = cur;
		if (!cur.error_seen) begin
			if (cur.trail_pending != 2'd0) begin
				if (trail_ok) begin
					nxt.trail_pending = cur.trail_pending - 2'd1;
				end else begin
					nxt.error_seen    = 1'b1;
					nxt.trail_pending = 2'd0;
				end
			end else if (lead_ok) begin
				nxt.trail_pending = lead_trails;
			end else begin
				nxt.error_seen    = 1'b1;
				nxt.trail_pending = 2'd0;
			end
		end
	end

	assign stream_ok = !nxt.error_seen && (nxt.trail_pending == 2'd0);

endmodule
